### rtl/utf8_stream_decoder_defines.svh
// Assertion macros shared by the UTF-8 stream decoder RTL.
// Users supply clk and rst in the including scope; no other dependencies.
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define U8D_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("utf8 decoder same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define U8D_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("utf8 decoder next-cycle check failed");

`endif

### rtl/u8d_pkg.sv
// Package for the UTF-8 stream decoder: request types, status types and
// lead-byte decode functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package u8d_pkg;

  localparam int unsigned CpWidth = 21;

  localparam logic [1:0] CONT_PREFIX = 2'b10;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } byte_req_t;

  typedef struct packed {
    logic [CpWidth-1:0] code_point;
    logic               decode_error;
  } cp_req_t;

  typedef struct packed {
    logic    valid;
    cp_req_t item;
  } step_res_t;

  typedef struct packed {
    logic busy;
  } step_status_t;

  function automatic logic [2:0] seq_len(input logic [4:0] top);
    logic [2:0] len;
    if (top[4] == 1'b0) begin
      len = 3'd1;
    end else begin
      unique case (top[3:0])
        4'b1000, 4'b1001, 4'b1010, 4'b1011: len = 3'd2;
        4'b1100, 4'b1101:                   len = 3'd3;
        4'b1110:                            len = 3'd4;
        default:                            len = 3'd0;
      endcase
    end
    return len;
  endfunction

  function automatic logic [7:0] lead_mask(input logic [2:0] len);
    logic [7:0] mask;
    unique case (len)
      3'd1:    mask = 8'h7F;
      3'd2:    mask = 8'h1F;
      3'd3:    mask = 8'h0F;
      3'd4:    mask = 8'h07;
      default: mask = 8'h00;
    endcase
    return mask;
  endfunction

endpackage

`default_nettype wire

### rtl/u8d_step.sv
// Sequence state of the UTF-8 decoder and the one-byte update step.
// Depends on u8d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8d_step (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 go,
  input  u8d_pkg::byte_req_t   req,
  output u8d_pkg::step_res_t   res,
  output u8d_pkg::step_status_t status
);

  logic [1:0]                  bytes_remaining, bytes_remaining_next;
  logic [u8d_pkg::CpWidth-1:0] partial_code, partial_code_next;
  logic                        error_pending, error_pending_next;

  logic [2:0]                  len;
  logic [1:0]                  rem_dec;
  logic                        cont_bad;

  assign len      = u8d_pkg::seq_len(req.data_byte[7:3]);
  assign rem_dec  = bytes_remaining - 2'd1;
  assign cont_bad = (req.data_byte[7:6] != u8d_pkg::CONT_PREFIX);

  always_comb begin
    bytes_remaining_next = bytes_remaining;
    partial_code_next    = partial_code;
    error_pending_next   = error_pending;
    res                  = '0;
    if (go) begin
      if (req.end_of_input) begin
        if (bytes_remaining != 2'd0) begin
          res.valid              = 1'b1;
          res.item.decode_error  = 1'b1;
          bytes_remaining_next   = 2'd0;
          partial_code_next      = '0;
          error_pending_next     = 1'b0;
        end
      end else if (bytes_remaining == 2'd0) begin
        if (len == 3'd0) begin
          res.valid             = 1'b1;
          res.item.decode_error = 1'b1;
        end else if (len == 3'd1) begin
          res.valid           = 1'b1;
          res.item.code_point = {13'd0, req.data_byte};
        end else begin
          partial_code_next    = {13'd0, req.data_byte & u8d_pkg::lead_mask(len)};
          bytes_remaining_next = 2'(len - 3'd1);
          error_pending_next   = 1'b0;
        end
      end else begin
        if (rem_dec == 2'd0) begin
          res.valid             = 1'b1;
          res.item.decode_error = error_pending | cont_bad;
          res.item.code_point   = (error_pending | cont_bad) ? '0 :
                                  {partial_code[14:0], req.data_byte[5:0]};
          bytes_remaining_next  = 2'd0;
          partial_code_next     = '0;
          error_pending_next    = 1'b0;
        end else begin
          bytes_remaining_next = rem_dec;
          partial_code_next    = {partial_code[14:0], req.data_byte[5:0]};
          error_pending_next   = error_pending | cont_bad;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining <= 2'd0;
      partial_code    <= '0;
      error_pending   <= 1'b0;
    end else begin
      bytes_remaining <= bytes_remaining_next;
      partial_code    <= partial_code_next;
      error_pending   <= error_pending_next;
    end
  end

  assign status.busy = (bytes_remaining != 2'd0);

endmodule

`default_nettype wire

### rtl/u8d_out_buf.sv
// Two-entry result buffer that decouples the decode step from the output stall.
// Depends on u8d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8d_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  u8d_pkg::cp_req_t push_item,
  output logic             full,
  output logic             valid,
  input  logic             stall,
  output u8d_pkg::cp_req_t item
);

  u8d_pkg::cp_req_t entries [2];
  logic [1:0]       count, count_next;
  logic             wr_ptr, rd_ptr;
  logic             pop;

  assign valid = (count != 2'd0);
  assign full  = (count == 2'd2);
  assign pop   = valid && !stall;
  assign item  = entries[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

### rtl/utf8_stream_decoder.sv
// Top level of the UTF-8 stream decoder: input register, decode step, result buffer.
// Depends on u8d_pkg, u8d_step, u8d_out_buf and utf8_stream_decoder_defines.svh.
//
//   Channel  Signals                          Payload
//   byte     byte_valid, byte_stall, byte_req  data_byte, end_of_input
//   cp       cp_valid, cp_stall, cp_req        code_point, decode_error
//
// One byte is accepted per cycle while byte_stall is low; the last byte of a
// sequence is held in the input register, its result in the two-entry buffer.
// Reset clears the sequence state and empties both stages.
// A stall on the cp channel backs up into byte_stall once the buffer is full.
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_stream_decoder_defines.svh"

module utf8_stream_decoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  u8d_pkg::byte_req_t byte_req,
  output logic               cp_valid,
  input  logic               cp_stall,
  output u8d_pkg::cp_req_t   cp_req
);

  logic                    s1_valid;
  u8d_pkg::byte_req_t      s1_req;
  logic                    accept;
  logic                    proc;
  logic                    buf_full;
  logic                    ascii_lead;
  u8d_pkg::step_res_t      res;
  u8d_pkg::step_status_t   status;

  assign proc       = s1_valid && (!buf_full || !cp_stall);
  assign byte_stall = s1_valid && !proc;
  assign accept     = byte_valid && !byte_stall;
  assign ascii_lead = proc && !s1_req.end_of_input && !status.busy && !s1_req.data_byte[7];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (proc) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req <= byte_req;
    end
  end

  u8d_step u_step (
    .clk    (clk),
    .rst    (rst),
    .go     (proc),
    .req    (s1_req),
    .res    (res),
    .status (status)
  );

  u8d_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res.valid),
    .push_item (res.item),
    .full      (buf_full),
    .valid     (cp_valid),
    .stall     (cp_stall),
    .item      (cp_req)
  );

  `U8D_ASSERT_NOW(a_err_zero_cp, cp_valid && cp_req.decode_error, cp_req.code_point == '0)
  `U8D_ASSERT_NEXT(a_eoi_idles, proc && s1_req.end_of_input, !status.busy)
  `U8D_ASSERT_NOW(a_ascii_emits, ascii_lead, res.valid)

endmodule

`default_nettype wire
